FILE: hdl/lph_pkg.sv
// ============================================================================
// lph_pkg: shared types and constants for the linear probe hash table
// Field widths, command and status codes, and the layout of one table entry.
// ============================================================================
`default_nettype none

package lph_pkg;

    // Field widths fixed by the item formats.
    localparam int KEY_W  = 31;
    localparam int ADDR_W = 32;
    localparam int SLOT_W = 4;

    // Operation carried by a request item.
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_t;

    // Outcome carried by a response item.
    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // One slot of the table as held in memory.
    typedef struct packed {
        logic              occupied;
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] address;
    } entry_t;

endpackage

`default_nettype wire

FILE: hdl/lph_if.sv
// ============================================================================
// lph_if: request and response channels of the linear probe hash table
// Valid/ready channels; an item moves when valid and ready are both high.
// ============================================================================
`default_nettype none

interface lph_req_if import lph_pkg::*; ();
    logic              valid;
    logic              ready;
    cmd_t              cmd;
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] record_address;

    modport source (output valid, output cmd, output key, output record_address,
                    input ready);
    modport sink   (input valid, input cmd, input key, input record_address,
                    output ready);
endinterface

interface lph_rsp_if import lph_pkg::*; ();
    logic              valid;
    logic              ready;
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] found_address;

    modport source (output valid, output status, output slot, output found_address,
                    input ready);
    modport sink   (input valid, input status, input slot, input found_address,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/lph_home.sv
// ============================================================================
// lph_home: home slot unit
// Computes key modulo TABLE_SIZE: the quotient comes from a multiplication
// by a rounded-up reciprocal, and the remainder from the low bits of the
// key minus quotient times TABLE_SIZE.
// ============================================================================
`default_nettype none

module lph_home import lph_pkg::*; #(
    parameter int TABLE_SIZE = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [KEY_W-1:0]              key,
    output logic                               done,
    output logic [$clog2(TABLE_SIZE)-1:0]      home
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int PROD_W = 2 * KEY_W + 1;
    localparam int QUO_W  = PROD_W - KEY_W - IDX_W;

    // Reciprocal rounded up; with this scaling the quotient is exact for
    // every key of KEY_W bits.
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << (KEY_W + IDX_W)) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
    localparam logic [KEY_W:0]   RECIP   = (KEY_W + 1)'(RECIP_FULL);
    localparam logic [IDX_W-1:0] MOD_LOW = IDX_W'(TABLE_SIZE);

    logic              busy_reg;
    logic              done_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [QUO_W-1:0]  quo_reg;

    logic [PROD_W-1:0] product;
    logic [IDX_W-1:0]  quo_mod;

    // Quotient by reciprocal multiplication.
    assign product = PROD_W'(key_reg) * PROD_W'(RECIP);

    // The remainder is below TABLE_SIZE, so the low bits of the difference
    // are all that is needed.
    assign quo_mod = quo_reg[IDX_W-1:0] * MOD_LOW;

    // Stage flags and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    // Key capture and quotient register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg <= key;
        end
        if (busy_reg)
        begin
            quo_reg <= product[PROD_W-1 -: QUO_W];
        end
    end

    assign done = done_reg;
    assign home = key_reg[IDX_W-1:0] - quo_mod;

endmodule

`default_nettype wire

FILE: hdl/lph_ram.sv
// ============================================================================
// lph_ram: slot memory
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read address.
// ============================================================================
`default_nettype none

module lph_ram import lph_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire entry_t                   wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output entry_t                        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hdl/linear_probe_hash_table.sv
// ============================================================================
// linear_probe_hash_table: open-addressed hash table with linear probing
// Maps a key to a record address; inserts and lookups probe forward from
// the key's home slot with wraparound.
// ============================================================================
// Usage:
//   request carries cmd (insert or look up), key and record_address; the
//   block takes one request item at a time. response returns exactly one
//   item per request: status, slot and found_address.
//   The home slot unit reduces the key modulo TABLE_SIZE by a reciprocal
//   multiplication; the probe then streams one slot read per cycle from the
//   slot memory and checks each entry as its read data returns.
//   A new request can be accepted in the cycle after the previous response
//   is loaded. After reset the block sweeps the memory to mark every slot
//   empty, one slot per cycle, and holds request.ready low.
//   The response is held in an output register; while the receiver stalls,
//   the block still accepts and processes the next request and waits with
//   its result until the output register is free.
// ============================================================================
`default_nettype none

module linear_probe_hash_table import lph_pkg::*; #(
    parameter int TABLE_SIZE = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lph_req_if.sink    request,
    lph_rsp_if.source  response
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [IDX_W:0]   SIZE_CNT = (IDX_W + 1)'(TABLE_SIZE);

    typedef enum logic [4:0] {
        S_CLEAR   = 5'b00001,
        S_IDLE    = 5'b00010,
        S_HASH    = 5'b00100,
        S_PROBE   = 5'b01000,
        S_DELIVER = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    cmd_t               cmd_reg, cmd_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [IDX_W:0]     issue_cnt_reg, issue_cnt_next;
    logic [IDX_W-1:0]   eval_cnt_reg, eval_cnt_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]   pend_slot_reg, pend_slot_next;
    status_t            res_status_reg, res_status_next;
    logic [IDX_W-1:0]   res_slot_reg, res_slot_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic               rsp_valid_reg, rsp_valid_next;
    status_t            rsp_status_reg, rsp_status_next;
    logic [SLOT_W-1:0]  rsp_slot_reg, rsp_slot_next;
    logic [ADDR_W-1:0]  rsp_addr_reg, rsp_addr_next;

    logic               home_start;
    logic               home_done;
    logic [IDX_W-1:0]   home_idx;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    entry_t             rd_entry;

    logic               probe_hit;
    logic               probe_last;
    logic               issue_more;
    logic               rsp_free;

    // Home slot unit.
    lph_home #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_home (
        .clk   (clk),
        .rst_n (rst_n),
        .start (home_start),
        .key   (key_next),
        .done  (home_done),
        .home  (home_idx)
    );

    // Slot memory.
    lph_ram #(
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    // Slot check on returning read data.
    assign probe_hit  = (cmd_reg == CMD_INSERT) ? !rd_entry.occupied
                        : (rd_entry.occupied && (rd_entry.key == key_reg));
    assign probe_last = (eval_cnt_reg == LAST_IDX);
    assign issue_more = (issue_cnt_reg != SIZE_CNT);
    assign rsp_free   = !rsp_valid_reg || response.ready;

    // Controller: clear sweep, hashing, probe stream and result hand-off.
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        addr_next       = addr_reg;
        rd_idx_next     = rd_idx_reg;
        issue_cnt_next  = issue_cnt_reg;
        eval_cnt_next   = eval_cnt_reg;
        rd_pend_next    = rd_pend_reg;
        pend_slot_next  = pend_slot_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_addr_next   = res_addr_reg;
        rsp_valid_next  = rsp_valid_reg && !response.ready;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        rsp_addr_next   = rsp_addr_reg;
        home_start      = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = clr_reg;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = rd_idx_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                if (request.valid)
                begin
                    cmd_next   = request.cmd;
                    key_next   = request.key;
                    addr_next  = request.record_address;
                    home_start = 1'b1;
                    state_next = S_HASH;
                end
            end

            S_HASH:
            begin
                if (home_done)
                begin
                    rd_idx_next    = home_idx;
                    issue_cnt_next = '0;
                    eval_cnt_next  = '0;
                    rd_pend_next   = 1'b0;
                    state_next     = S_PROBE;
                end
            end

            S_PROBE:
            begin
                // Issue the next slot read while earlier reads are checked.
                if (issue_more)
                begin
                    rd_en          = 1'b1;
                    rd_idx_next    = (rd_idx_reg == LAST_IDX) ? '0
                                     : rd_idx_reg + IDX_W'(1);
                    issue_cnt_next = issue_cnt_reg + (IDX_W + 1)'(1);
                    rd_pend_next   = 1'b1;
                    pend_slot_next = rd_idx_reg;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end

                // Check the entry read in the previous cycle.
                if (rd_pend_reg)
                begin
                    if (probe_hit)
                    begin
                        res_slot_next = pend_slot_reg;
                        if (cmd_reg == CMD_INSERT)
                        begin
                            wr_en            = 1'b1;
                            wr_addr          = pend_slot_reg;
                            wr_data.occupied = 1'b1;
                            wr_data.key      = key_reg;
                            wr_data.address  = addr_reg;
                            res_status_next  = ST_INSERTED;
                            res_addr_next    = '0;
                        end
                        else
                        begin
                            res_status_next = ST_FOUND;
                            res_addr_next   = rd_entry.address;
                        end
                        rd_pend_next = 1'b0;
                        state_next   = S_DELIVER;
                    end
                    else if (probe_last)
                    begin
                        res_status_next = (cmd_reg == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
                        res_slot_next   = '0;
                        res_addr_next   = '0;
                        rd_pend_next    = 1'b0;
                        state_next      = S_DELIVER;
                    end
                    else
                    begin
                        eval_cnt_next = eval_cnt_reg + IDX_W'(1);
                    end
                end
            end

            S_DELIVER:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_slot_next   = SLOT_W'(res_slot_reg);
                    rsp_addr_next   = res_addr_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            issue_cnt_reg <= '0;
            eval_cnt_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            issue_cnt_reg <= issue_cnt_next;
            eval_cnt_reg  <= eval_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        addr_reg       <= addr_next;
        rd_idx_reg     <= rd_idx_next;
        pend_slot_reg  <= pend_slot_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_addr_reg   <= res_addr_next;
        rsp_status_reg <= rsp_status_next;
        rsp_slot_reg   <= rsp_slot_next;
        rsp_addr_reg   <= rsp_addr_next;
    end

    // Channel outputs.
    assign request.ready          = (state_reg == S_IDLE);
    assign response.valid         = rsp_valid_reg;
    assign response.status        = rsp_status_reg;
    assign response.slot          = rsp_slot_reg;
    assign response.found_address = rsp_addr_reg;

    // A probe writes the memory only to place an inserted key.
    a_probe_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (state_reg == S_PROBE)) |-> (cmd_reg == CMD_INSERT))
        else $error("slot memory written during a lookup probe");

    // Only a found lookup returns a nonzero address.
    a_addr_only_found: assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && (response.status != ST_FOUND)) |-> (response.found_address == '0))
        else $error("nonzero found_address on a response that is not found");

    // Read data in flight is checked only while probing.
    a_pend_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == S_PROBE))
        else $error("pending slot read outside the probe");

    // The home slot arrives while the controller waits for it.
    a_home_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        home_done |-> (state_reg == S_HASH))
        else $error("home slot completed outside hashing");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ============================================================================
// tb_top: testbench for the linear probe hash table
// Drives insert and lookup items through the request channel. A local copy
// of the table predicts each response, and every response item is checked
// field by field against the oldest prediction. The run covers idle and
// stall phases and one long receiver hold-off.
// ============================================================================
`default_nettype none

module tb_top;
    import lph_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 16;
    localparam int N_RANDOM    = 740;
    localparam int KEY_POOL_N  = 24;
    localparam int HOLD_CYCLES = 150;
    localparam int HOLD_AT     = 30;
    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        cmd_t              cmd;
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] addr;
    } req_item_t;

    typedef struct {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] found;
    } rsp_item_t;

    logic clk;
    logic rst_n;

    lph_req_if req_ch ();
    lph_rsp_if rsp_ch ();

    linear_probe_hash_table #(.TABLE_SIZE(SLOTS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    // Local copy of the table contents.
    bit                tbl_used [SLOTS];
    logic [KEY_W-1:0]  tbl_key  [SLOTS];
    logic [ADDR_W-1:0] tbl_addr [SLOTS];

    req_item_t  cmd_backlog[$];
    rsp_item_t  pending_outcomes[$];
    logic [KEY_W-1:0] key_pool [KEY_POOL_N];

    int n_items;
    int offered;
    int req_count;
    int rsp_count;
    int quiet_cycles;
    int mismatches;
    int hold_left;
    bit hold_done;

    req_item_t accepted;
    rsp_item_t got;
    rsp_item_t want;

    // Walk the table from the key's home slot, one lap at most, and update
    // the local copy on a successful insert.
    function automatic rsp_item_t probe_table(req_item_t r);
        rsp_item_t res;
        int        s;
        s = int'(r.key % SLOTS);
        res.slot  = '0;
        res.found = '0;
        if (r.cmd == CMD_INSERT) begin
            res.status = ST_FULL;
            for (int n = 0; n < SLOTS; n++) begin
                if (!tbl_used[s]) begin
                    tbl_used[s] = 1'b1;
                    tbl_key[s]  = r.key;
                    tbl_addr[s] = r.addr;
                    res.status  = ST_INSERTED;
                    res.slot    = SLOT_W'(s);
                    break;
                end
                s = (s + 1 >= SLOTS) ? 0 : s + 1;
            end
        end
        else begin
            res.status = ST_NOT_FOUND;
            for (int n = 0; n < SLOTS; n++) begin
                if (tbl_used[s] && tbl_key[s] == r.key) begin
                    res.status = ST_FOUND;
                    res.slot   = SLOT_W'(s);
                    res.found  = tbl_addr[s];
                    break;
                end
                s = (s + 1 >= SLOTS) ? 0 : s + 1;
            end
        end
        return res;
    endfunction

    function automatic req_item_t make_req(cmd_t c, logic [KEY_W-1:0] k,
                                           logic [ADDR_W-1:0] a);
        req_item_t r;
        r.cmd  = c;
        r.key  = k;
        r.addr = a;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch on response %0d: %s", $realtime, rsp_count, what);
        mismatches++;
    endtask

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sender: offers the next queued item once the current one is taken.
    always @(negedge clk) begin
        int        gap_pct;
        req_item_t nxt;
        if (rst_n && !(req_ch.valid && req_count < offered)) begin
            case ((offered * 4) / n_items)
                1:       gap_pct = 46;
                3:       gap_pct = 8;
                default: gap_pct = 0;
            endcase
            if (cmd_backlog.size() > 0 && $urandom_range(99) >= gap_pct) begin
                nxt = cmd_backlog.pop_front();
                req_ch.valid          <= 1'b1;
                req_ch.cmd            <= nxt.cmd;
                req_ch.key            <= nxt.key;
                req_ch.record_address <= nxt.addr;
                offered++;
            end
            else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls by phase, plus one long hold-off early on so
    // that the block backs up and stalls its request side.
    always @(negedge clk) begin
        int stall_pct;
        if (rst_n) begin
            case ((rsp_count * 4) / n_items)
                2:       stall_pct = 46;
                3:       stall_pct = 8;
                default: stall_pct = 0;
            endcase
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!hold_done && req_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end
            else begin
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Monitor: predicts on each accepted request, checks each accepted
    // response, and watches for a hang.
    always @(posedge clk) begin
        if (rst_n) begin
            quiet_cycles++;
            if (req_ch.valid && req_ch.ready) begin
                accepted.cmd  = req_ch.cmd;
                accepted.key  = req_ch.key;
                accepted.addr = req_ch.record_address;
                pending_outcomes.push_back(probe_table(accepted));
                req_count++;
                quiet_cycles = 0;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.status = rsp_ch.status;
                got.slot   = rsp_ch.slot;
                got.found  = rsp_ch.found_address;
                if (pending_outcomes.size() == 0) begin
                    report_mismatch("response item with no request outstanding");
                end
                else begin
                    want = pending_outcomes.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.slot !== want.slot)
                        report_mismatch($sformatf("slot %0d, expected %0d",
                                                  got.slot, want.slot));
                    if (got.found !== want.found)
                        report_mismatch($sformatf("found_address %h, expected %h",
                                                  got.found, want.found));
                end
                rsp_count++;
                quiet_cycles = 0;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [KEY_W-1:0] k;
        cmd_t             c;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.cmd     = CMD_INSERT;
        req_ch.key     = '0;
        req_ch.record_address = '0;
        rsp_ch.ready   = 1'b0;
        offered        = 0;
        req_count      = 0;
        rsp_count      = 0;
        quiet_cycles   = 0;
        mismatches     = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        foreach (tbl_used[i]) begin
            tbl_used[i] = 1'b0;
            tbl_key[i]  = '0;
            tbl_addr[i] = '0;
        end

        // Directed part: empty-table lookups, key extremes, wraparound,
        // a duplicate key, and lookups that pass over empty slots.
        cmd_backlog.push_back(make_req(CMD_LOOKUP, '0, '0));
        cmd_backlog.push_back(make_req(CMD_LOOKUP, '1, '1));
        cmd_backlog.push_back(make_req(CMD_INSERT, '0, '0));
        cmd_backlog.push_back(make_req(CMD_INSERT, '1, '1));
        cmd_backlog.push_back(make_req(CMD_INSERT, 31'd15, 32'hA5A5_A5A5));
        cmd_backlog.push_back(make_req(CMD_INSERT, '0, 32'h1234_5678));
        cmd_backlog.push_back(make_req(CMD_LOOKUP, '0, 32'hFFFF_FFFF));
        cmd_backlog.push_back(make_req(CMD_LOOKUP, 31'd15, '0));
        cmd_backlog.push_back(make_req(CMD_LOOKUP, '1, '0));
        cmd_backlog.push_back(make_req(CMD_LOOKUP, 31'd16, '0));
        cmd_backlog.push_back(make_req(CMD_INSERT, 31'h5555_5555, 32'h5A5A_5A5A));
        cmd_backlog.push_back(make_req(CMD_LOOKUP, 31'h5555_5555, '0));
        cmd_backlog.push_back(make_req(CMD_INSERT, 31'h2AAA_AAA7, 32'h8000_0001));
        cmd_backlog.push_back(make_req(CMD_LOOKUP, 31'h2AAA_AAA7, 32'h7FFF_FFFE));

        // Random part: keys mostly from a small pool so that lookups hit and
        // duplicates occur; the table fills early and later inserts see it full.
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL_N; i++)
            key_pool[i] = KEY_W'($urandom);
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(99) < 70)
                k = key_pool[$urandom_range(KEY_POOL_N - 1)];
            else
                k = KEY_W'($urandom);
            c = ($urandom_range(99) < 25) ? CMD_INSERT : CMD_LOOKUP;
            cmd_backlog.push_back(make_req(c, k, $urandom));
        end
        n_items = cmd_backlog.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_count < n_items)
            @(posedge clk);
        while (pending_outcomes.size() > 0)
            @(posedge clk);
        repeat (SLOTS + 16) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/lph_pkg.sv
hdl/lph_if.sv
hdl/lph_home.sv
hdl/lph_ram.sv
hdl/linear_probe_hash_table.sv
tb/tb_top.sv
